[hw/rtl/twcr_pkg.sv]
// Package of types, constants and codes shared by the textured wall column renderer.
`default_nettype none
package twcr_pkg;

    localparam int SCREEN_HEIGHT = 64;
    localparam int TEX_DIM_MAX   = 64;

    localparam int DIM_W      = 7;
    localparam int Y_W        = $clog2(SCREEN_HEIGHT);
    localparam int LH_W       = $clog2(SCREEN_HEIGHT + 1);
    localparam int TIDX_W     = 12;
    localparam int REGION_W   = $clog2(TEX_DIM_MAX * TEX_DIM_MAX);
    localparam int RIDX_W     = (REGION_W < TIDX_W) ? REGION_W : TIDX_W;
    localparam int STORE_DEPTH = 4 * TEX_DIM_MAX * TEX_DIM_MAX;
    localparam int STORE_AW   = $clog2(STORE_DEPTH);
    localparam int DIV_STEPS  = 14;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_REG_COUNT = 8;

    localparam logic [31:0] DARK_MASK = 32'd8355711;

    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_EAST  = 2'd2;
    localparam logic [1:0] TEX_WEST  = 2'd3;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_COLUMN = 1'b1
    } twcr_kind_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_FRAC,
        F_TX,
        F_DIV_LH,
        F_RANGE,
        F_DIV_Q0,
        F_DIV_S
    } twcr_fstate_t;

    typedef struct packed {
        logic               action;
        logic [1:0]         texture_select;
        logic [11:0]        texel_index;
        logic [31:0]        texel_color;
        logic [9:0]         column_x;
        logic               hit_side;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] ray_dir_x;
        logic signed [31:0] ray_dir_y;
        logic [30:0]        perp_dist;
        logic signed [7:0]  view_offset;
    } twcr_in_t;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } twcr_out_t;

    typedef struct packed {
        twcr_kind_t        kind;
        logic [1:0]        sel;
        logic [TIDX_W-1:0] tidx;
        logic [31:0]       color;
        logic [9:0]        x;
        logic              side;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  tx;
        logic [Y_W-1:0]    y_start;
        logic [Y_W-1:0]    y_end;
        logic [DIM_W-1:0]  q0;
        logic [DIM_W-1:0]  r0;
        logic [DIM_W-1:0]  sq;
        logic [DIM_W-1:0]  sr;
        logic [LH_W-1:0]   lh;
    } twcr_entry_t;

endpackage
`default_nettype wire

[hw/rtl/twcr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module twcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[hw/rtl/twcr_front.sv]
// Front end: accepts transactions, holds the texture sizes and prepares column work.
`default_nettype none
module twcr_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire twcr_pkg::twcr_in_t             in_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [twcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [twcr_pkg::DIM_W-1:0]     cfg_data,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output twcr_pkg::twcr_entry_t               push_data
);
    import twcr_pkg::*;

    twcr_fstate_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic pend_reg, pend_next;

    logic [DIM_W-1:0] tw_reg [4];
    logic [DIM_W-1:0] th_reg [4];

    twcr_kind_t        kind_reg;
    logic [1:0]        sel_reg;
    logic [TIDX_W-1:0] tidx_reg;
    logic [31:0]       color_reg;
    logic [9:0]        x_reg;
    logic              side_reg;
    logic              mirror_reg;
    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [30:0]       perp_reg;
    logic signed [7:0] head_reg;
    logic [15:0]       pos_lo_reg;
    logic [31:0]       dir_reg;
    logic [31:0]       prod_reg;
    logic [31:0]       frac_reg;
    logic [DIM_W-1:0]  tx_reg;
    logic [LH_W-1:0]   lh_reg;
    logic [Y_W-1:0]    start_reg;
    logic [Y_W-1:0]    end_reg;
    logic [DIM_W-1:0]  q0_reg;
    logic [DIM_W-1:0]  r0_reg;
    logic [DIM_W-1:0]  sq_reg;
    logic [DIM_W-1:0]  sr_reg;
    logic [30:0]       rem_reg;
    logic [DIV_STEPS-1:0] num_reg;
    logic [DIV_STEPS-1:0] quot_reg;
    logic [30:0]       div_reg;

    logic              accept;
    logic              rdx_pos, rdy_pos, acc_side;
    logic [1:0]        acc_sel;
    logic [DIM_W-1:0]  acc_w, acc_h;
    logic [31:0]       trial, diff;
    logic              ge;
    logic [30:0]       rem_step;
    logic [DIV_STEPS-1:0] quot_step;
    logic              div_last;
    logic [38:0]       txw;
    logic [DIM_W-1:0]  tx_raw, tx_c;
    logic signed [9:0] head_ext, half_ext, s_raw, e_raw, start_c, end_c, n_c;
    logic              empty_c;
    logic [14:0]       nh_c;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                tw_reg[i] <= DIM_W'(TEX_DIM_MAX);
                th_reg[i] <= DIM_W'(TEX_DIM_MAX);
            end
        end
        else if (cfg_valid && (32'(cfg_index) < CFG_REG_COUNT))
        begin
            if (cfg_index[0])
            begin
                th_reg[cfg_index[2:1]] <= cfg_data;
            end
            else
            begin
                tw_reg[cfg_index[2:1]] <= cfg_data;
            end
        end
    end

    assign rdx_pos  = !in_data.ray_dir_x[31] && (in_data.ray_dir_x != 32'sd0);
    assign rdy_pos  = !in_data.ray_dir_y[31] && (in_data.ray_dir_y != 32'sd0);
    assign acc_side = in_data.hit_side;

    always_comb
    begin
        if (in_data.action == ACT_LOAD)
        begin
            acc_sel = in_data.texture_select;
        end
        else if (!acc_side)
        begin
            acc_sel = rdx_pos ? TEX_NORTH : TEX_SOUTH;
        end
        else
        begin
            acc_sel = rdy_pos ? TEX_EAST : TEX_WEST;
        end
        acc_w = (tw_reg[acc_sel] == '0) ? DIM_W'(1) : tw_reg[acc_sel];
        acc_h = (th_reg[acc_sel] == '0) ? DIM_W'(1) : th_reg[acc_sel];
    end

    assign trial     = {rem_reg, num_reg[DIV_STEPS-1]};
    assign ge        = trial >= {1'b0, div_reg};
    assign diff      = trial - {1'b0, div_reg};
    assign rem_step  = ge ? diff[30:0] : trial[30:0];
    assign quot_step = {quot_reg[DIV_STEPS-2:0], ge};
    assign div_last  = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign txw    = 39'(frac_reg) * 39'(w_reg);
    assign tx_raw = txw[38:32];
    assign tx_c   = mirror_reg ? (w_reg - tx_raw - DIM_W'(1)) : tx_raw;

    always_comb
    begin
        head_ext = 10'(head_reg);
        half_ext = $signed(10'(lh_reg >> 1));
        s_raw    = $signed(10'(SCREEN_HEIGHT / 2)) + head_ext - half_ext;
        e_raw    = $signed(10'(SCREEN_HEIGHT / 2)) + head_ext + half_ext;
        start_c  = s_raw[9] ? 10'sd0 : s_raw;
        end_c    = (e_raw >= $signed(10'(SCREEN_HEIGHT))) ?
                   $signed(10'(SCREEN_HEIGHT - 1)) : e_raw;
        empty_c  = (lh_reg == '0) || (start_c >= end_c);
        n_c      = start_c - s_raw;
        nh_c     = 15'(n_c[7:0]) * 15'(h_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        in_ready   = 1'b0;
        push_valid = pend_reg;
        if (pend_reg && push_ready)
        begin
            pend_next = 1'b0;
        end
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = !pend_reg;
                if (accept)
                begin
                    if (in_data.action == ACT_LOAD)
                    begin
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        state_next = F_MUL;
                    end
                end
            end
            F_MUL:    state_next = F_FRAC;
            F_FRAC:   state_next = F_TX;
            F_TX:     state_next = (perp_reg[30:16] == '0) ? F_RANGE : F_DIV_LH;
            F_DIV_LH:
            begin
                if (div_last)
                begin
                    state_next = F_RANGE;
                end
            end
            F_RANGE:  state_next = empty_c ? F_IDLE : F_DIV_Q0;
            F_DIV_Q0:
            begin
                if (div_last)
                begin
                    state_next = F_DIV_S;
                end
            end
            F_DIV_S:
            begin
                if (div_last)
                begin
                    state_next = F_IDLE;
                    pend_next  = 1'b1;
                end
            end
            default:  state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == F_DIV_LH || state_reg == F_DIV_Q0 || state_reg == F_DIV_S)
        begin
            cnt_reg <= div_last ? '0 : cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    kind_reg   <= twcr_kind_t'(in_data.action);
                    sel_reg    <= acc_sel;
                    tidx_reg   <= in_data.texel_index;
                    color_reg  <= in_data.texel_color;
                    x_reg      <= in_data.column_x;
                    side_reg   <= acc_side;
                    mirror_reg <= acc_side ? in_data.ray_dir_y[31] : rdx_pos;
                    w_reg      <= acc_w;
                    h_reg      <= acc_h;
                    perp_reg   <= in_data.perp_dist;
                    head_reg   <= in_data.view_offset;
                    pos_lo_reg <= acc_side ? in_data.pos_x[15:0] : in_data.pos_y[15:0];
                    dir_reg    <= acc_side ? in_data.ray_dir_x : in_data.ray_dir_y;
                end
            end
            F_MUL:    prod_reg <= 32'(32'(perp_reg) * dir_reg);
            F_FRAC:   frac_reg <= prod_reg + {pos_lo_reg, 16'd0};
            F_TX:
            begin
                tx_reg   <= tx_c;
                lh_reg   <= LH_W'(SCREEN_HEIGHT);
                rem_reg  <= 31'(SCREEN_HEIGHT * 4);
                num_reg  <= '0;
                quot_reg <= '0;
                div_reg  <= perp_reg;
            end
            F_DIV_LH:
            begin
                rem_reg  <= rem_step;
                num_reg  <= num_reg << 1;
                quot_reg <= quot_step;
                if (div_last)
                begin
                    lh_reg <= LH_W'(quot_step);
                end
            end
            F_RANGE:
            begin
                start_reg <= start_c[Y_W-1:0];
                end_reg   <= end_c[Y_W-1:0];
                rem_reg   <= '0;
                num_reg   <= nh_c[DIV_STEPS-1:0];
                quot_reg  <= '0;
                div_reg   <= 31'(lh_reg);
            end
            F_DIV_Q0:
            begin
                rem_reg  <= rem_step;
                num_reg  <= num_reg << 1;
                quot_reg <= quot_step;
                if (div_last)
                begin
                    q0_reg   <= quot_step[DIM_W-1:0];
                    r0_reg   <= rem_step[DIM_W-1:0];
                    rem_reg  <= '0;
                    num_reg  <= DIV_STEPS'(h_reg);
                    quot_reg <= '0;
                end
            end
            F_DIV_S:
            begin
                rem_reg  <= rem_step;
                num_reg  <= num_reg << 1;
                quot_reg <= quot_step;
                if (div_last)
                begin
                    sq_reg <= quot_step[DIM_W-1:0];
                    sr_reg <= rem_step[DIM_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        push_data.kind    = kind_reg;
        push_data.sel     = sel_reg;
        push_data.tidx    = tidx_reg;
        push_data.color   = color_reg;
        push_data.x       = x_reg;
        push_data.side    = side_reg;
        push_data.w       = w_reg;
        push_data.h       = h_reg;
        push_data.tx      = tx_reg;
        push_data.y_start = start_reg;
        push_data.y_end   = end_reg;
        push_data.q0      = q0_reg;
        push_data.r0      = r0_reg;
        push_data.sq      = sq_reg;
        push_data.sr      = sr_reg;
        push_data.lh      = lh_reg;
    end
endmodule
`default_nettype wire

[hw/rtl/twcr_queue.sv]
// Two-entry queue between the front end and the back end.
`default_nettype none
module twcr_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire twcr_pkg::twcr_entry_t push_data,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output twcr_pkg::twcr_entry_t      pop_data
);
    import twcr_pkg::*;

    twcr_entry_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/twcr_back.sv]
// Back end: texel writes, row stepping, texture reads and the result register.
`default_nettype none
module twcr_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire twcr_pkg::twcr_entry_t pop_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output twcr_pkg::twcr_out_t        out_data
);
    import twcr_pkg::*;

    logic             active_reg;
    logic [Y_W-1:0]   y_reg, end_reg;
    logic [9:0]       x_reg;
    logic             side_reg;
    logic [1:0]       sel_reg;
    logic [DIM_W-1:0] w_reg, h_reg, tx_reg, q_reg, r_reg, sq_reg, sr_reg;
    logic [LH_W-1:0]  lh_reg;

    logic             rd_v_reg;
    logic [9:0]       rd_x_reg;
    logic [Y_W-1:0]   rd_y_reg;
    logic             rd_side_reg;
    logic             rd_last_reg;

    logic             out_v_reg;
    twcr_out_t        out_reg;

    logic             rd_move, issue, wr_en, last_c;
    logic [DIM_W-1:0] ty;
    logic [13:0]      lin;
    logic [STORE_AW-1:0] raddr, waddr;
    logic [31:0]      rdata;
    logic [DIM_W:0]   r_sum;
    logic             wrap;

    assign rd_move   = !out_v_reg || out_ready;
    assign issue     = active_reg && (!rd_v_reg || rd_move);
    assign pop_ready = !active_reg;
    assign wr_en     = pop_valid && pop_ready && (pop_data.kind == ACT_LOAD);
    assign last_c    = ((Y_W + 1)'(y_reg) + (Y_W + 1)'(1)) == (Y_W + 1)'(end_reg);

    assign ty    = q_reg & (h_reg - DIM_W'(1));
    assign lin   = 14'(ty) * 14'(w_reg) + 14'(tx_reg);
    assign raddr = {sel_reg, REGION_W'(lin[RIDX_W-1:0])};
    assign waddr = {pop_data.sel, REGION_W'(pop_data.tidx[RIDX_W-1:0])};
    assign r_sum = {1'b0, r_reg} + {1'b0, sr_reg};
    assign wrap  = r_sum >= (DIM_W + 1)'(lh_reg);

    twcr_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (pop_data.color),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rd_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (!active_reg && pop_valid && (pop_data.kind == ACT_COLUMN))
            begin
                active_reg <= 1'b1;
            end
            else if (issue && last_c)
            begin
                active_reg <= 1'b0;
            end
            if (issue)
            begin
                rd_v_reg <= 1'b1;
            end
            else if (rd_move)
            begin
                rd_v_reg <= 1'b0;
            end
            if (rd_v_reg && rd_move)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!active_reg && pop_valid)
        begin
            y_reg    <= pop_data.y_start;
            end_reg  <= pop_data.y_end;
            x_reg    <= pop_data.x;
            side_reg <= pop_data.side;
            sel_reg  <= pop_data.sel;
            w_reg    <= pop_data.w;
            h_reg    <= pop_data.h;
            tx_reg   <= pop_data.tx;
            q_reg    <= pop_data.q0;
            r_reg    <= pop_data.r0;
            sq_reg   <= pop_data.sq;
            sr_reg   <= pop_data.sr;
            lh_reg   <= pop_data.lh;
        end
        else if (issue)
        begin
            y_reg <= y_reg + Y_W'(1);
            if (wrap)
            begin
                r_reg <= DIM_W'(r_sum - (DIM_W + 1)'(lh_reg));
                q_reg <= q_reg + sq_reg + DIM_W'(1);
            end
            else
            begin
                r_reg <= r_sum[DIM_W-1:0];
                q_reg <= q_reg + sq_reg;
            end
        end
        if (issue)
        begin
            rd_x_reg    <= x_reg;
            rd_y_reg    <= y_reg;
            rd_side_reg <= side_reg;
            rd_last_reg <= last_c;
        end
        if (rd_v_reg && rd_move)
        begin
            out_reg.pixel_x     <= rd_x_reg;
            out_reg.pixel_y     <= 6'(rd_y_reg);
            out_reg.pixel_color <= rd_side_reg ? ((rdata >> 1) & DARK_MASK) : rdata;
            out_reg.last_pixel  <= rd_last_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    a_issue_active: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> active_reg)
        else $error("Row issued without an active column.");

    a_no_write_in_column: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !active_reg && !issue)
        else $error("Texel write during a column.");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (y_reg < end_reg))
        else $error("Row counter passed the end of the draw range.");
endmodule
`default_nettype wire

[hw/rtl/textured_wall_column_renderer.sv]
// Top level of the textured wall column renderer: front end, queue and back end.
//
//   Channel  Direction  Handshake               Payload
//   in       to block   in_valid / in_ready     in_data (twcr_in_t)
//   out      from block out_valid / out_ready   out_data (twcr_out_t)
//   cfg      to block   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A column transaction passes through the front end, which runs up to three 14-step restoring
// divisions, then the back end gives one result per cycle while out_ready stays high, bounded
// by the single read port of the texture store.
// Reset clears control state only; the texture store holds unknown data until written.
// The queue lets the front end prepare the next column while the back end still draws.
`default_nettype none
module textured_wall_column_renderer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire twcr_pkg::twcr_in_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output twcr_pkg::twcr_out_t                 out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [twcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [twcr_pkg::DIM_W-1:0]     cfg_data
);
    import twcr_pkg::*;

    logic        push_valid, push_ready, pop_valid, pop_ready;
    twcr_entry_t push_data, pop_data;

    twcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    twcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    twcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the textured wall column renderer.
`default_nettype none
module tb;
    import twcr_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 400;
    localparam int TEX_LIMIT       = 4;
    localparam int PRELOAD_TEXELS  = TEX_LIMIT * TEX_LIMIT;
    localparam int ITEMS_PER_PHASE = 6;

    typedef struct {
        twcr_in_t item;
        bit       has_count;
        int       pixel_count;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    twcr_in_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    twcr_out_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    logic [31:0]      texel_mem [0:STORE_DEPTH-1];
    logic [DIM_W-1:0] tex_size [0:3][0:1];
    twcr_out_t        pixel_queue [$];
    int               mismatches = 0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    logic             hold_off = 1'b0;
    int               quiet_cycles = 0;
    directed_row_t    directed [$];

    textured_wall_column_renderer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int render_column(twcr_in_t c);
        logic [1:0]  sel;
        int unsigned w, h, tx, n, ty, addr;
        longint      lh, start, stop, off;
        logic [63:0] pos, dir, sum;
        logic [31:0] frac, colour;
        twcr_out_t   px;
        int          count;
        count = 0;
        if (c.hit_side == 1'b0)
            sel = ($signed(c.ray_dir_x) > 0) ? TEX_NORTH : TEX_SOUTH;
        else
            sel = ($signed(c.ray_dir_y) > 0) ? TEX_EAST : TEX_WEST;
        w = (tex_size[sel][0] != 0) ? tex_size[sel][0] : 1;
        h = (tex_size[sel][1] != 0) ? tex_size[sel][1] : 1;
        if (c.perp_dist == 0)
            lh = SCREEN_HEIGHT;
        else
            lh = (longint'(SCREEN_HEIGHT) << 16) / longint'(c.perp_dist);
        if (lh > SCREEN_HEIGHT)
            lh = SCREEN_HEIGHT;
        off = longint'(c.view_offset);
        start = SCREEN_HEIGHT / 2 + off - lh / 2;
        if (start < 0)
            start = 0;
        stop = SCREEN_HEIGHT / 2 + off + lh / 2;
        if (stop >= SCREEN_HEIGHT)
            stop = SCREEN_HEIGHT - 1;
        if (start >= stop || lh <= 0)
            return 0;
        pos = (c.hit_side == 1'b0) ? {{32{c.pos_y[31]}}, c.pos_y}
                                   : {{32{c.pos_x[31]}}, c.pos_x};
        dir = (c.hit_side == 1'b0) ? {{32{c.ray_dir_y[31]}}, c.ray_dir_y}
                                   : {{32{c.ray_dir_x[31]}}, c.ray_dir_x};
        sum = {33'd0, c.perp_dist} * dir + (pos << 16);
        frac = sum[31:0];
        tx = int'((64'(frac) * 64'(w)) >> 32);
        if ((c.hit_side == 1'b0 && $signed(c.ray_dir_x) > 0) ||
            (c.hit_side == 1'b1 && $signed(c.ray_dir_y) < 0))
            tx = w - tx - 1;
        n = int'(start - off - SCREEN_HEIGHT / 2 + lh / 2);
        for (longint y = start; y < stop; y++)
        begin
            ty = int'(((longint'(n) + count) * h) / lh) & (h - 1);
            addr = ((ty * w + tx) & 32'hFFF) % (TEX_DIM_MAX * TEX_DIM_MAX);
            colour = texel_mem[sel * TEX_DIM_MAX * TEX_DIM_MAX + addr];
            if (c.hit_side)
                colour = (colour >> 1) & DARK_MASK;
            px.pixel_x = c.column_x;
            px.pixel_y = y[5:0];
            px.pixel_color = colour;
            px.last_pixel = (y + 1 == stop);
            pixel_queue.push_back(px);
            count++;
        end
        return count;
    endfunction

    function automatic int apply_item(twcr_in_t it);
        if (it.action == ACT_LOAD)
        begin
            texel_mem[it.texture_select * TEX_DIM_MAX * TEX_DIM_MAX +
                      (it.texel_index % (TEX_DIM_MAX * TEX_DIM_MAX))] = it.texel_color;
            return 0;
        end
        return render_column(it);
    endfunction

    task automatic send_item(twcr_in_t it, output int count);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        count = apply_item(it);
    endtask

    task automatic write_reg(int idx, int value);
        wait (pixel_queue.size() == 0);
        repeat (80) @(posedge clk);
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= value[DIM_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < CFG_REG_COUNT)
            tex_size[idx / 2][idx % 2] = value[DIM_W-1:0];
    endtask

    function automatic twcr_in_t make_load(int sel, int idx, logic [31:0] colour);
        twcr_in_t it;
        it = '0;
        it.action = ACT_LOAD;
        it.texture_select = sel[1:0];
        it.texel_index = idx[11:0];
        it.texel_color = colour;
        return it;
    endfunction

    function automatic twcr_in_t make_column(int side, int rdx, int rdy, int perp,
                                            int offset);
        twcr_in_t it;
        it = '0;
        it.action = ACT_COLUMN;
        it.column_x = 10'($urandom_range(1023));
        it.hit_side = side[0];
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.ray_dir_x = rdx;
        it.ray_dir_y = rdy;
        it.perp_dist = perp[30:0];
        it.view_offset = offset[7:0];
        return it;
    endfunction

    function automatic twcr_in_t random_item();
        twcr_in_t it;
        int       pick;
        it = '0;
        it.texture_select = 2'($urandom_range(3));
        if ($urandom_range(3) == 0)
            it.texel_index = 12'($urandom_range(4095));
        else
            it.texel_index = 12'($urandom_range(PRELOAD_TEXELS - 1));
        it.texel_color = $urandom;
        it.column_x = 10'($urandom_range(1023));
        it.hit_side = 1'($urandom_range(1));
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.ray_dir_x = $urandom;
        it.ray_dir_y = $urandom;
        pick = $urandom_range(9);
        if (pick == 0)
            it.perp_dist = 31'($urandom);
        else if (pick == 1)
            it.perp_dist = '0;
        else
            it.perp_dist = 31'($urandom_range(32'h0005_0000, 32'h0000_8000));
        pick = $urandom_range(9);
        if (pick == 0)
            it.view_offset = 8'($urandom);
        else if (pick < 4)
            it.view_offset = '0;
        else
            it.view_offset = 8'($urandom_range(128) - 64);
        it.action = ($urandom_range(4) == 0) ? ACT_LOAD : ACT_COLUMN;
        return it;
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pixel_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected pixel transaction: %p", out_data);
            end
            else
            begin
                if (out_data !== pixel_queue[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Pixel mismatch: expected %p, got %p",
                                 pixel_queue[0], out_data);
                end
                void'(pixel_queue.pop_front());
            end
        end
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int count;
        int value;
        twcr_in_t it;
        for (int t = 0; t < 4; t++)
        begin
            tex_size[t][0] = 64;
            tex_size[t][1] = 64;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Texture sizes stay at or below four, so every texel that a column can reach
        // lies in the first sixteen entries of its texture, all written here.
        for (int t = 0; t < 4; t++)
            for (int a = 0; a < PRELOAD_TEXELS; a++)
                send_item(make_load(t, a, $urandom), count);
        in_valid <= 1'b0;
        for (int r = 0; r < 2 * CFG_REG_COUNT; r++)
            write_reg(r, (r < CFG_REG_COUNT) ? TEX_LIMIT : 1);

        directed.push_back('{make_load(0, 0, 32'h0000_0000), 1, 0});
        directed.push_back('{make_load(3, 4095, 32'hFFFF_FFFF), 1, 0});
        directed.push_back('{make_load(1, 2048, 32'h8080_8080), 1, 0});
        directed.push_back('{make_load(2, 15, 32'h7F7F_7F7F), 1, 0});
        directed.push_back('{make_column(0, 1, 0, 0, 0), 1, 63});
        directed.push_back('{make_column(0, 0, 0, 0, 0), 1, 63});
        directed.push_back('{make_column(1, 0, 1, 0, 0), 1, 63});
        directed.push_back('{make_column(1, 0, -1, 0, 0), 1, 63});
        directed.push_back('{make_column(0, 1, 1, 32'h7FFF_FFFF, 0), 1, 0});
        directed.push_back('{make_column(0, 1, 1, 0, 64), 1, 0});
        directed.push_back('{make_column(1, 1, 1, 0, -64), 1, 0});
        directed.push_back('{make_column(0, 1, 1, 0, 127), 1, 0});
        directed.push_back('{make_column(1, 1, 1, 0, -128), 1, 0});
        directed.push_back('{make_column(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000,
                                         0), 0, 0});
        directed.push_back('{make_column(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                         10), 0, 0});
        directed.push_back('{make_column(0, -5, 3, 32'h0000_3000, -20), 0, 0});
        directed.push_back('{make_column(1, 7, 9, 32'h0004_0000, 40), 0, 0});
        directed.push_back('{make_column(0, 1, -1, 32'h0000_FFFF, 1), 0, 0});
        directed.push_back('{make_column(1, -1, 1, 32'h0010_0001, -1), 0, 0});
        foreach (directed[i])
        begin
            send_item(directed[i].item, count);
            if (directed[i].has_count && count != directed[i].pixel_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Row %0d: expected %0d pixels, predicted %0d",
                             i, directed[i].pixel_count, count);
            end
        end
        in_valid <= 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            for (int r = 0; r < CFG_REG_COUNT; r++)
            begin
                case (phase)
                    0: value = (r % 2) ? 1 : 0;
                    1: value = (r % 2) ? (1 << $urandom_range(2))
                                       : $urandom_range(TEX_LIMIT);
                    2: value = TEX_LIMIT;
                    default: value = (r % 2) ? (1 << $urandom_range(2))
                                             : $urandom_range(TEX_LIMIT, 1);
                endcase
                if (phase == 4 && r == 3)
                    value = 3;
                write_reg(r, value);
            end
            idle_pct = (phase == 1 || phase == 3) ? 64 : 0;
            stall_pct = (phase == 2 || phase == 3) ? 64 : 0;
            if (phase == 3)
            begin
                idle_pct = 12;
                stall_pct = 12;
            end
            if (phase == 4)
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Full-height columns first, so that the held-off output fills the block.
                if (phase == 4 && i < 4)
                    it = make_column(i % 2, $urandom, $urandom, 0, 0);
                else
                    it = random_item();
                send_item(it, count);
            end
            in_valid <= 1'b0;
        end

        wait (pixel_queue.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pixel_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hw/rtl/twcr_pkg.sv
hw/rtl/twcr_ram.sv
hw/rtl/twcr_front.sv
hw/rtl/twcr_queue.sv
hw/rtl/twcr_back.sv
hw/rtl/textured_wall_column_renderer.sv
tb/sv/tb.sv
